@@ design/brz_pkg.sv @@
// ----------------------------------------------------------------------------
// brz_pkg
// Shared types and constants of the line rasteriser: microcode control word,
// step codes, configuration register indexes and the status passed back to
// the sequencer.
// ----------------------------------------------------------------------------
package brz_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_VISIBLE_ROW = 2'd2;

  // Field widths
  localparam int COORD_W = 6;
  localparam int PIX_W   = 8;
  localparam int ADDR_W  = 12;
  localparam int COLOR_W = 24;
  localparam int DIM_W   = 7;
  localparam int ROW_W   = 6;
  localparam int ERR_W   = 9;

  // Microprogram steps
  localparam int UPC_W = 2;
  localparam logic [UPC_W-1:0] STEP_WAIT  = 2'd0;
  localparam logic [UPC_W-1:0] STEP_SETUP = 2'd1;
  localparam logic [UPC_W-1:0] STEP_PLOT  = 2'd2;

  // Condition under which a step repeats
  typedef enum logic [1:0] {
    HOLD_NEVER,
    HOLD_NO_INPUT,
    HOLD_NOT_LAST
  } hold_sel_t;

  typedef struct packed {
    logic             accept;   // take a command word
    logic             setup;    // order endpoints, derive deltas
    logic             plot;     // emit one pixel and advance
    hold_sel_t        hold_sel;
    logic             jump;     // leave to target instead of the next step
    logic [UPC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic at_last;
  } seq_status_t;

  typedef struct packed {
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
    logic [ROW_W-1:0] first_visible_row;
  } cfg_t;

  // Control store
  function automatic ctl_word_t ucode_rom(input logic [UPC_W-1:0] step);
    ctl_word_t w;
    w = '{accept: 1'b0, setup: 1'b0, plot: 1'b0, hold_sel: HOLD_NEVER,
          jump: 1'b1, target: STEP_WAIT};
    unique case (step)
      STEP_WAIT: begin
        w.accept   = 1'b1;
        w.hold_sel = HOLD_NO_INPUT;
        w.jump     = 1'b0;
      end
      STEP_SETUP: begin
        w.setup = 1'b1;
        w.jump  = 1'b0;
      end
      STEP_PLOT: begin
        w.plot     = 1'b1;
        w.hold_sel = HOLD_NOT_LAST;
        w.jump     = 1'b1;
        w.target   = STEP_WAIT;
      end
      default: begin
        w.jump   = 1'b1;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/brz_sequencer.sv @@
// ----------------------------------------------------------------------------
// brz_sequencer
// Step counter over the control store: repeats a step while its hold
// condition stands, then jumps or advances.
// ----------------------------------------------------------------------------
module brz_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  brz_pkg::seq_status_t status,
  output brz_pkg::ctl_word_t   ctl
);
  import brz_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             hold;

  // Fetch the control word of the current step
  assign ctl = ucode_rom(upc);

  // Evaluate the hold condition
  always_comb begin
    case (ctl.hold_sel)
      HOLD_NO_INPUT: hold = !status.in_valid;
      HOLD_NOT_LAST: hold = !(status.out_free && status.at_last);
      default:       hold = 1'b0;
    endcase
  end

  // Pick the next step
  always_comb begin
    if (hold) begin
      upc_next = upc;
    end else if (ctl.jump) begin
      upc_next = ctl.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ design/brz_datapath.sv @@
// ----------------------------------------------------------------------------
// brz_datapath
// Command registers, endpoint ordering, error-term stepping, screen
// mapping with clipping and the output word register.
// ----------------------------------------------------------------------------
module brz_datapath #(
  parameter int MAX_DIM = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  brz_pkg::ctl_word_t                  ctl,
  input  brz_pkg::cfg_t                       cfg,
  output brz_pkg::seq_status_t                status,
  input  logic                                in_valid,
  input  logic signed [brz_pkg::COORD_W-1:0]  start_x,
  input  logic signed [brz_pkg::COORD_W-1:0]  start_y,
  input  logic signed [brz_pkg::COORD_W-1:0]  end_x,
  input  logic signed [brz_pkg::COORD_W-1:0]  end_y,
  input  logic        [brz_pkg::COLOR_W-1:0]  color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [brz_pkg::PIX_W-1:0]    pixel_x,
  output logic signed [brz_pkg::PIX_W-1:0]    pixel_y,
  output logic        [brz_pkg::ADDR_W-1:0]   pixel_address,
  output logic        [brz_pkg::COLOR_W-1:0]  pixel_color,
  output logic                                visible,
  output logic                                last
);
  import brz_pkg::*;

  localparam int CW = $clog2(MAX_DIM);

  // Command word
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic        [COLOR_W-1:0] cmd_color;

  // Stepping state
  logic signed [COORD_W-1:0] px, py;
  logic        [COORD_W-1:0] major, minor;
  logic                      dir_neg;
  logic                      xmajor;
  logic signed [ERR_W-1:0]   err;
  logic        [CW-1:0]      rem;

  // Setup terms
  logic signed [COORD_W:0]   dx, dy, adx, ady, md;
  logic                      xmaj_s, swap_s;
  logic signed [COORD_W-1:0] px_s, py_s, ex_s, ey_s;
  logic signed [COORD_W:0]   major_d;
  logic        [COORD_W-1:0] minor_s;
  logic        [CW-1:0]      rem_s;

  // Step terms
  logic signed [ERR_W-1:0]   err_sum;
  logic signed [ERR_W:0]     two_err;
  logic                      step_minor;
  logic signed [COORD_W-1:0] minor_inc;

  // Pixel terms
  logic signed [PIX_W-1:0]   sx, sy;
  logic                      vis;
  logic        [2*DIM_W-1:0] prod;
  logic        [ADDR_W-1:0]  addr;
  logic                      out_free;
  logic                      plot_fire;

  assign out_free  = !out_valid || out_ready;
  assign plot_fire = ctl.plot && out_free;

  assign status.in_valid = in_valid;
  assign status.out_free = out_free;
  assign status.at_last  = (rem == '0);

  // Order endpoints and derive deltas
  always_comb begin
    dx     = COORD_W'(0) + (COORD_W+1)'(bx) - (COORD_W+1)'(ax);
    dy     = (COORD_W+1)'(by) - (COORD_W+1)'(ay);
    adx    = dx[COORD_W] ? -dx : dx;
    ady    = dy[COORD_W] ? -dy : dy;
    xmaj_s = (adx >= ady);
    swap_s = xmaj_s ? !(ax < bx) : !(ay < by);
    px_s   = swap_s ? bx : ax;
    py_s   = swap_s ? by : ay;
    ex_s   = swap_s ? ax : bx;
    ey_s   = swap_s ? ay : by;
    if (xmaj_s) begin
      major_d = (COORD_W+1)'(ex_s) - (COORD_W+1)'(px_s);
      md      = (COORD_W+1)'(ey_s) - (COORD_W+1)'(py_s);
    end else begin
      major_d = (COORD_W+1)'(ey_s) - (COORD_W+1)'(py_s);
      md      = (COORD_W+1)'(ex_s) - (COORD_W+1)'(px_s);
    end
    minor_s = md[COORD_W] ? COORD_W'(-md) : COORD_W'(md);
    // Cap the pixel count at MAX_DIM
    if (32'(major_d[COORD_W-1:0]) > 32'(MAX_DIM - 1)) begin
      rem_s = CW'(MAX_DIM - 1);
    end else begin
      rem_s = CW'(major_d[COORD_W-1:0]);
    end
  end

  // Advance the error term
  always_comb begin
    err_sum    = err + $signed({{(ERR_W-COORD_W){1'b0}}, minor});
    two_err    = {err_sum, 1'b0};
    step_minor = (two_err >= $signed({{(ERR_W+1-COORD_W){1'b0}}, major}));
    minor_inc  = dir_neg ? -COORD_W'(1) : COORD_W'(1);
  end

  // Map to screen and clip
  always_comb begin
    sx   = PIX_W'(px) + $signed({2'b00, cfg.screen_width[DIM_W-1:1]});
    sy   = PIX_W'(py) + $signed({2'b00, cfg.screen_height[DIM_W-1:1]});
    vis  = !sx[PIX_W-1] && (sx < $signed({1'b0, cfg.screen_width}))
        && (sy >= $signed({2'b00, cfg.first_visible_row}))
        && (sy < $signed({1'b0, cfg.screen_height}));
    prod = {{DIM_W{1'b0}}, sy[DIM_W-1:0]} * {{DIM_W{1'b0}}, cfg.screen_width};
    addr = vis ? (prod[ADDR_W-1:0] + {{(ADDR_W-DIM_W){1'b0}}, sx[DIM_W-1:0]}) : '0;
  end

  // Take the command word
  always_ff @(posedge clk) begin
    if (ctl.accept && in_valid) begin
      ax        <= start_x;
      ay        <= start_y;
      bx        <= end_x;
      by        <= end_y;
      cmd_color <= color;
    end
  end

  // Set up, then step one pixel per plot
  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      px      <= px_s;
      py      <= py_s;
      major   <= major_d[COORD_W-1:0];
      minor   <= minor_s;
      dir_neg <= md[COORD_W];
      xmajor  <= xmaj_s;
      err     <= '0;
      rem     <= rem_s;
    end else if (plot_fire) begin
      rem <= rem - CW'(1);
      err <= step_minor ? (err_sum - $signed({{(ERR_W-COORD_W){1'b0}}, major})) : err_sum;
      if (xmajor) begin
        px <= px + COORD_W'(1);
        if (step_minor) begin
          py <= py + minor_inc;
        end
      end else begin
        py <= py + COORD_W'(1);
        if (step_minor) begin
          px <= px + minor_inc;
        end
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (plot_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (plot_fire) begin
      pixel_x       <= sx;
      pixel_y       <= sy;
      pixel_address <= addr;
      pixel_color   <= cmd_color;
      visible       <= vis;
      last          <= (rem == '0);
    end
  end

endmodule

@@ design/bresenham_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Line rasteriser: turns a two-endpoint line command into a stream of
// clipped screen pixels with framebuffer addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command word: two endpoints
//   relative to the screen centre and a colour. Output channel
//   (out_valid/out_ready) gives one word per pixel, the final one with last.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes screen
//   width, screen height and first visible row; write it only while idle.
//   A line of N pixels (N = major delta + 1, at most MAX_DIM) occupies the
//   block from its command to its last pixel: the wait step takes the
//   command, the setup step orders the endpoints, then the microcoded plot
//   step gives one pixel per cycle while the output register is free.
//   A new command is taken only once the last pixel sits in the output
//   register. When the receiver stalls, the output register holds its word
//   and the plot step waits; nothing is dropped.
//   Reset returns the sequencer to its wait step, empties the output
//   register and sets width 64, height 64, first visible row 0.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int MAX_DIM = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [brz_pkg::COORD_W-1:0]   start_x,
  input  logic signed [brz_pkg::COORD_W-1:0]   start_y,
  input  logic signed [brz_pkg::COORD_W-1:0]   end_x,
  input  logic signed [brz_pkg::COORD_W-1:0]   end_y,
  input  logic        [brz_pkg::COLOR_W-1:0]   color,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [brz_pkg::PIX_W-1:0]     pixel_x,
  output logic signed [brz_pkg::PIX_W-1:0]     pixel_y,
  output logic        [brz_pkg::ADDR_W-1:0]    pixel_address,
  output logic        [brz_pkg::COLOR_W-1:0]   pixel_color,
  output logic                                 visible,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [brz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [brz_pkg::CFG_DATA_W-1:0] cfg_data
);
  import brz_pkg::*;

  cfg_t        cfg;
  ctl_word_t   ctl;
  seq_status_t status;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctl.accept;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width      <= DIM_W'(64);
      cfg.screen_height     <= DIM_W'(64);
      cfg.first_visible_row <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:      cfg.screen_width      <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT:     cfg.screen_height     <= cfg_data[DIM_W-1:0];
        REG_FIRST_VISIBLE_ROW: cfg.first_visible_row <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  brz_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  brz_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cfg           (cfg),
    .status        (status),
    .in_valid      (in_valid),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .color         (color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .visible       (visible),
    .last          (last)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the line rasteriser against a behavioural line stepper. Line commands
// go in over the input channel while both channels idle at random. Every
// pixel word is compared field by field with the oldest expected pixel, under
// several screen settings from the smallest to the largest register values.
// ----------------------------------------------------------------------------
module testbench;
  import brz_pkg::*;

  localparam int MAX_DIM = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_STALL = 300;
  localparam int RANDOM_LINES = 78;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [ADDR_W-1:0]       addr;
    logic [COLOR_W-1:0]      color;
    logic                    vis;
    logic                    last;
  } pixel_t;

  // Expected pixel store with its own copy of the screen registers
  class pixel_scoreboard;
    logic [DIM_W-1:0] width = 7'd64;
    logic [DIM_W-1:0] height = 7'd64;
    logic [ROW_W-1:0] first_row = 6'd0;
    pixel_t pending_pixels[$];
    int mismatches = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCREEN_WIDTH: width = data;
        REG_SCREEN_HEIGHT: height = data;
        REG_FIRST_VISIBLE_ROW: first_row = data[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    // Step along the major axis and queue one pixel per step
    function void rasterise_line(logic signed [COORD_W-1:0] sx0, logic signed [COORD_W-1:0] sy0,
                                 logic signed [COORD_W-1:0] ex0, logic signed [COORD_W-1:0] ey0,
                                 logic [COLOR_W-1:0] col);
      int ax, ay, bx, by, t, major, minor, dir, err, n, px, py, scr_x, scr_y, w, h;
      bit x_major, vis;
      pixel_t p;
      ax = sx0;
      ay = sy0;
      bx = ex0;
      by = ey0;
      w = width;
      h = height;
      x_major = ((ax > bx) ? ax - bx : bx - ax) >= ((ay > by) ? ay - by : by - ay);
      // order the endpoints so the major coordinate ascends
      if ((x_major && !(ax < bx)) || (!x_major && !(ay < by))) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      px = ax;
      py = ay;
      if (x_major) begin
        major = bx - ax;
        minor = (by > ay) ? by - ay : ay - by;
        dir = (by > ay) ? 1 : ((by < ay) ? -1 : 0);
      end else begin
        major = by - ay;
        minor = (bx > ax) ? bx - ax : ax - bx;
        dir = (bx > ax) ? 1 : ((bx < ax) ? -1 : 0);
      end
      n = major + 1;
      if (n > MAX_DIM) n = MAX_DIM;
      err = 0;
      for (int i = 0; i < n; i++) begin
        scr_x = px + w / 2;
        scr_y = py + h / 2;
        vis = scr_x >= 0 && scr_x < w && scr_y >= int'(first_row) && scr_y < h;
        p.x = scr_x[PIX_W-1:0];
        p.y = scr_y[PIX_W-1:0];
        p.addr = vis ? ADDR_W'(scr_y * w + scr_x) : '0;
        p.color = col;
        p.vis = vis;
        p.last = (i == n - 1);
        pending_pixels.push_back(p);
        err += minor;
        if (x_major) begin
          px++;
          if (2 * err >= major) begin py += dir; err -= major; end
        end else begin
          py++;
          if (2 * err >= major) begin px += dir; err -= major; end
        end
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel x=%0d y=%0d addr=%0d color=%h vis=%b last=%b",
                   $realtime, got.x, got.y, got.addr, got.color, got.vis, got.last);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
          got.color !== want.color || got.vis !== want.vis || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: pixel mismatch: expected x=%0d y=%0d addr=%0d color=%h vis=%b last=%b",
                   $realtime, want.x, want.y, want.addr, want.color, want.vis, want.last);
          $display("    got x=%0d y=%0d addr=%0d color=%h vis=%b last=%b",
                   got.x, got.y, got.addr, got.color, got.vis, got.last);
        end
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] start_x = '0;
  logic signed [COORD_W-1:0] start_y = '0;
  logic signed [COORD_W-1:0] end_x = '0;
  logic signed [COORD_W-1:0] end_y = '0;
  logic [COLOR_W-1:0] color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [ADDR_W-1:0] pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic visible;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  int send_idle_pct = 9;
  int recv_idle_pct = 65;
  bit long_stall_due = 1'b0;
  int stall_cycles = 0;
  int cycles = 0;

  bresenham_line_rasterizer #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y), .color(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_address(pixel_address),
    .pixel_color(pixel_color), .visible(visible), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bresenham_line_rasterizer verification failed");
      $finish;
    end
  end

  // Receiver: hold off once for a long stretch when asked, else stall at random
  always @(negedge clk) begin
    if (long_stall_due && stall_cycles < LONG_STALL) begin
      out_ready <= 1'b0;
      stall_cycles++;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every pixel word taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel('{x: pixel_x, y: pixel_y, addr: pixel_address, color: pixel_color,
                       vis: visible, last: last});
  end

  // Offer one line command; entered and left at a falling edge
  task automatic send_line(logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
                           logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey,
                           logic [COLOR_W-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    color <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.rasterise_line(sx, sy, ex, ey, col);
    @(negedge clk);
  endtask

  // Random lines half the time, with short, axis-aligned, point and corner lines mixed in
  task automatic random_line();
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    int kind;
    kind = $urandom_range(9);
    sx = COORD_W'($urandom_range(63));
    sy = COORD_W'($urandom_range(63));
    ex = COORD_W'($urandom_range(63));
    ey = COORD_W'($urandom_range(63));
    case (kind)
      5, 6: begin
        ex = sx + COORD_W'($urandom_range(6) - 3);
        ey = sy + COORD_W'($urandom_range(6) - 3);
      end
      7: if ($urandom_range(1)) ey = sy; else ex = sx;
      8: begin ex = sx; ey = sy; end
      9: begin
        sx = $urandom_range(1) ? 6'sd31 : -6'sd32;
        sy = $urandom_range(1) ? 6'sd31 : -6'sd32;
        ex = $urandom_range(1) ? 6'sd31 : -6'sd32;
        ey = $urandom_range(1) ? 6'sd31 : -6'sd32;
      end
      default: ;
    endcase
    send_line(sx, sy, ex, ey, COLOR_W'($urandom));
  endtask

  // One register write; caller lowers cfg_valid after the batch
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] row, bit poke_unused);
    write_cfg(REG_SCREEN_WIDTH, w);
    write_cfg(REG_SCREEN_HEIGHT, h);
    write_cfg(REG_FIRST_VISIBLE_ROW, row);
    if (poke_unused) write_cfg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Drop the input and wait until every expected pixel has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines under the reset screen
    send_line(0, 0, 0, 0, 24'h000000);
    send_line(-32, -32, -32, -32, 24'hFFFFFF);
    send_line(31, 31, 31, 31, 24'h123456);
    send_line(-32, 0, 31, 0, 24'hAAAAAA);
    send_line(31, 5, -32, 5, 24'h555555);
    send_line(0, -32, 0, 31, 24'hFFFFFF);
    send_line(3, 31, 3, -32, 24'h000000);
    send_line(-32, -32, 31, 31, 24'hF0F0F0);
    send_line(31, -32, -32, 31, 24'h0F0F0F);
    send_line(-32, 31, 31, -32, 24'hFFFFFF);
    send_line(-32, -10, 31, 20, 24'h000001);
    send_line(20, 31, -5, -32, 24'h800000);
    send_line(-5, 31, 20, -32, 24'h7FFFFF);
    send_line(10, 0, -10, 3, 24'hABCDEF);
    send_line(0, 0, 1, 1, 24'h000000);
    send_line(0, 0, 2, 1, 24'hFFFFFF);
    send_line(0, 0, 1, 2, 24'h010203);

    // Random phases, each under its own screen setting; the idling mix changes every second phase
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: configure(7'd1, 7'd1, 7'd0, 1'b0);
        1: configure(7'd127, 7'd127, 7'd63, 1'b0);
        2: configure(7'd0, 7'd0, CFG_DATA_W'($urandom_range(63)), 1'b1);
        3: configure(CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(1, 64)),
                     {1'b1, 6'($urandom_range(63))}, 1'b1);
        default: configure(7'd64, 7'd64, 7'd0, 1'b0);
      endcase
      send_idle_pct = (ph < 2) ? 9 : ((ph < 4) ? 65 : 0);
      recv_idle_pct = (ph < 2) ? 65 : ((ph < 4) ? 9 : 0);
      // fill the block behind a stalled receiver
      if (ph == 4) long_stall_due = 1'b1;
      repeat (RANDOM_LINES) random_line();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("bresenham_line_rasterizer verification clean");
    else
      $display("bresenham_line_rasterizer verification failed");
    $finish;
  end

endmodule
